/* src/csfr_pkg.sv */
// ----------------------------------------------------------------------------
// csfr_pkg
// Shared types, constants and CRC step functions for the status frame
// receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package csfr_pkg;

  // Frame layout
  localparam int          MAX_FRAME_DEF = 64;
  localparam int          MIN_FRAME     = 17;
  localparam int          STORE_DEPTH   = 16;
  localparam int          STORE_AW      = 4;
  localparam int          HDR_BYTES     = 4;   // bytes covered by the header CRC-8
  localparam int          HDR_CRC_POS   = 4;   // position of the header CRC-8 byte
  localparam logic [7:0]  START_BYTE    = 8'hA5;
  localparam logic [7:0]  TYPE_STATUS   = 8'h00;

  // CRC-8 (reflected poly 0x8C, init 0xFF) and CRC-16/MCRF4XX, both reflected
  localparam logic [7:0]  CRC8_INIT     = 8'hFF;
  localparam logic [7:0]  CRC8_POLY_R   = 8'h8C;
  localparam logic [15:0] CRC16_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC16_POLY_R  = 16'h8408;

  // Configuration port
  localparam int          CFG_AW        = 3;
  localparam int          CFG_DW        = 32;
  localparam int          FLEN_W        = 7;

  typedef enum logic {
    REG_FRAME_LENGTH = 1'b0,
    REG_CHECK_BOTH   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [FLEN_W-1:0] frame_length;
    logic              check_both;
  } cfg_t;

  // One byte through the reflected CRC-8
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY_R) : (c >> 1);
    end
    return c;
  endfunction

  // One byte through the reflected CRC-16
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY_R) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/csfr_in_if.sv */
// ----------------------------------------------------------------------------
// csfr_in_if
// Byte channel into the receiver: one received byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface csfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* src/csfr_out_if.sv */
// ----------------------------------------------------------------------------
// csfr_out_if
// Result channel: one item per frame end with check flags and status record.
// ----------------------------------------------------------------------------
`default_nettype none

interface csfr_out_if;
  logic        valid;
  logic        ready;
  logic        header_ok;
  logic        body_ok;
  logic        record_updated;
  logic [7:0]  frame_type;
  logic [7:0]  pc_shutdown;
  logic [7:0]  robot_color;
  logic [31:0] yaw_bits;
  logic [31:0] pitch_bits;
  logic [15:0] forward_bits;

  modport source (output valid, output header_ok, output body_ok, output record_updated,
                  output frame_type, output pc_shutdown, output robot_color,
                  output yaw_bits, output pitch_bits, output forward_bits, input ready);
  modport sink   (input valid, input header_ok, input body_ok, input record_updated,
                  input frame_type, input pc_shutdown, input robot_color,
                  input yaw_bits, input pitch_bits, input forward_bits, output ready);
endinterface

`default_nettype wire

/* src/csfr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// csfr_cfg_regs
// APB-style register file: frame length and CRC-16 byte check mode.
// ----------------------------------------------------------------------------
`default_nettype none

module csfr_cfg_regs
  import csfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_reg_t reg_sel;
  logic     wr_en;

  // Register index is the word address
  assign reg_sel    = cfg_reg_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_length <= FLEN_W'(MIN_FRAME);
      cfg_r.check_both   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FRAME_LENGTH: cfg_r.frame_length <= cfg_pwdata[FLEN_W-1:0];
        REG_CHECK_BOTH:   cfg_r.check_both   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      REG_FRAME_LENGTH: cfg_prdata = {{(CFG_DW-FLEN_W){1'b0}}, cfg_r.frame_length};
      REG_CHECK_BOTH:   cfg_prdata = {{(CFG_DW-1){1'b0}}, cfg_r.check_both};
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* src/crc_checked_status_frame_receiver.sv */
// ----------------------------------------------------------------------------
// crc_checked_status_frame_receiver
// Groups received bytes into fixed-length frames, checks the header CRC-8
// and frame CRC-16, and keeps the last good status record.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   : one received byte per item, valid/ready handshake.
//   out_if  : one item per frame end: header_ok, body_ok, record_updated,
//             frame_type and the stored status record after this frame.
//   cfg_*   : APB-style port. 0x0 frame_length (clamped to 17..MAX_FRAME),
//             0x4 check_both_crc_bytes. Write only while the block is idle.
// Frames are counted from reset with no resynchronization on the start byte.
// Throughput: one byte per cycle. Each byte's CRC update, header check and
// store write finish in the cycle it is accepted; the frame-end result is
// loaded into the output register at that edge.
// A result waiting in the output register only holds off the next byte that
// would end another frame; all other bytes keep flowing.
// Reset: frame counter and CRCs restart, status record reads as zero,
// frame_length 17, single-byte CRC-16 check. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checked_status_frame_receiver
  import csfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  csfr_in_if.sink                in_if,
  csfr_out_if.source             out_if,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int CNT_W = $clog2(MAX_FRAME);
  localparam int LW    = $clog2(MAX_FRAME + 2);
  localparam int CMP_W = (LW > FLEN_W) ? LW : FLEN_W;

  cfg_t cfg;

  csfr_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Frame state
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc8_r, crc8_nxt;
  logic [15:0]      crc16_r, crc16_nxt;
  logic             hdr_good_r, hdr_good_nxt;
  logic [7:0]       prev_r;
  logic [7:0]       store_r [STORE_DEPTH];

  // Status record
  logic [7:0]  shutdown_r, shutdown_nxt;
  logic [7:0]  color_r, color_nxt;
  logic [31:0] yaw_r, yaw_nxt;
  logic [31:0] pitch_r, pitch_nxt;
  logic [15:0] forward_r, forward_nxt;

  // Output register
  logic        out_valid_r;
  logic        hdr_ok_r, body_ok_r, updated_r;
  logic [7:0]  type_r;

  logic [CMP_W-1:0] flen, len, pos_p1, pos_p2;
  logic             frame_end, accept, body_ok, updated;
  logic [7:0]       b;

  assign b = in_if.rx_byte;

  // Effective frame length
  always_comb begin
    flen = CMP_W'(cfg.frame_length);
    if (flen < CMP_W'(MIN_FRAME))      len = CMP_W'(MIN_FRAME);
    else if (flen > CMP_W'(MAX_FRAME)) len = CMP_W'(MAX_FRAME);
    else                               len = flen;
  end

  assign pos_p1    = CMP_W'(pos_r) + CMP_W'(1);
  assign pos_p2    = CMP_W'(pos_r) + CMP_W'(2);
  assign frame_end = (pos_p1 >= len);

  // A held result only blocks the byte that ends the next frame
  assign in_if.ready = !frame_end || !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  // Frame-end checks
  always_comb begin
    body_ok = (crc16_r[15:8] == b);
    if (cfg.check_both) body_ok = body_ok && (crc16_r[7:0] == prev_r);
  end
  assign updated = hdr_good_r && body_ok && (store_r[1] == TYPE_STATUS);

  // Per-byte state update
  always_comb begin
    pos_nxt      = pos_r;
    crc8_nxt     = crc8_r;
    crc16_nxt    = crc16_r;
    hdr_good_nxt = hdr_good_r;
    if (CMP_W'(pos_r) < CMP_W'(HDR_BYTES)) begin
      crc8_nxt = crc8_next(crc8_r, b);
    end else if (CMP_W'(pos_r) == CMP_W'(HDR_CRC_POS)) begin
      hdr_good_nxt = (store_r[0] == START_BYTE) && (crc8_r == b);
    end
    if (pos_p2 < len) crc16_nxt = crc16_next(crc16_r, b);
    if (frame_end) begin
      pos_nxt      = '0;
      crc8_nxt     = CRC8_INIT;
      crc16_nxt    = CRC16_INIT;
      hdr_good_nxt = 1'b0;
    end else begin
      pos_nxt = pos_r + CNT_W'(1);
    end
  end

  // Status record after a good status frame
  always_comb begin
    shutdown_nxt = shutdown_r;
    color_nxt    = color_r;
    yaw_nxt      = yaw_r;
    pitch_nxt    = pitch_r;
    forward_nxt  = forward_r;
    if (updated) begin
      shutdown_nxt = store_r[2];
      color_nxt    = store_r[3];
      yaw_nxt      = {store_r[8], store_r[7], store_r[6], store_r[5]};
      pitch_nxt    = {store_r[12], store_r[11], store_r[10], store_r[9]};
      forward_nxt  = {store_r[14], store_r[13]};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc8_r     <= CRC8_INIT;
      crc16_r    <= CRC16_INIT;
      hdr_good_r <= 1'b0;
      prev_r     <= '0;
      shutdown_r <= '0;
      color_r    <= '0;
      yaw_r      <= '0;
      pitch_r    <= '0;
      forward_r  <= '0;
    end else if (accept) begin
      pos_r      <= pos_nxt;
      crc8_r     <= crc8_nxt;
      crc16_r    <= crc16_nxt;
      hdr_good_r <= hdr_good_nxt;
      prev_r     <= b;
      if (frame_end) begin
        shutdown_r <= shutdown_nxt;
        color_r    <= color_nxt;
        yaw_r      <= yaw_nxt;
        pitch_r    <= pitch_nxt;
        forward_r  <= forward_nxt;
      end
    end
  end

  // Byte store for the first bytes of the frame
  always_ff @(posedge clk) begin
    if (accept && (CMP_W'(pos_r) < CMP_W'(STORE_DEPTH))) begin
      store_r[pos_r[STORE_AW-1:0]] <= b;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_end) begin
      hdr_ok_r  <= hdr_good_r;
      body_ok_r <= body_ok;
      updated_r <= updated;
      type_r    <= store_r[1];
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.header_ok      = hdr_ok_r;
  assign out_if.body_ok        = body_ok_r;
  assign out_if.record_updated = updated_r;
  assign out_if.frame_type     = type_r;
  assign out_if.pc_shutdown    = shutdown_r;
  assign out_if.robot_color    = color_r;
  assign out_if.yaw_bits       = yaw_r;
  assign out_if.pitch_bits     = pitch_r;
  assign out_if.forward_bits   = forward_r;

endmodule

`default_nettype wire
